[hdl/chcb_pkg.sv]
// ============================================================================
// Canonical Huffman code builder: shared definitions
// Field widths, table geometry and register map of the code builder.
// ============================================================================
`default_nettype none

package chcb_pkg;

	// Table geometry: one count byte per code length.
	localparam int NUM_COUNTS = 16;
	localparam int CNT_IDX_W  = 4;

	// Field widths.
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 5;
	localparam int CODE_W   = 16;
	localparam int NCODE_W  = CODE_W + 1;
	localparam int SYMS_W   = 12;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index, taken from paddr[2].
	localparam logic [0:0] REG_MAX_CODE_LENGTH = 1'b0;

	// Reset value of max_code_length.
	localparam logic [LEN_W-1:0] MAX_CODE_LENGTH_RESET = 5'd16;

endpackage : chcb_pkg

`default_nettype wire

[hdl/chcb_in_if.sv]
// ============================================================================
// Code builder input channel
// Carries one table byte and its start-of-table mark with valid/ready.
// ============================================================================
`default_nettype none

interface chcb_in_if;
	import chcb_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] table_byte;
	logic              table_start;

	modport source (output valid, output table_byte, output table_start, input ready);
	modport sink   (input valid, input table_byte, input table_start, output ready);

endinterface : chcb_in_if

`default_nettype wire

[hdl/chcb_out_if.sv]
// ============================================================================
// Code builder output channel
// Carries one assigned code with its symbol, length and status.
// ============================================================================
`default_nettype none

interface chcb_out_if;
	import chcb_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] symbol;
	logic [CODE_W-1:0] code_word;
	logic [LEN_W-1:0]  code_length;
	logic              build_status;
	logic              last_symbol;

	modport source (
		output valid, output symbol, output code_word, output code_length,
		output build_status, output last_symbol, input ready
	);
	modport sink (
		input valid, input symbol, input code_word, input code_length,
		input build_status, input last_symbol, output ready
	);

endinterface : chcb_out_if

`default_nettype wire

[hdl/canonical_huffman_code_builder_top.sv]
// Each count byte is written to the count memory; the 16th starts a pass that sums
// the counts, during which no byte is taken.
// A symbol byte visits S_ADV, plus S_LOAD and S_ADV per skipped empty length, set by
// the single count memory read port and the shared shift/increment/compare step.
// The result sits in an output register; a new byte is taken while it waits.
// Reset (arst_n low, asynchronous) clears all control state; counts are not cleared.
// ============================================================================
// Canonical Huffman code builder
// Assigns canonical JPEG-style codes to symbols of a table streamed byte-wise.
// ============================================================================
`default_nettype none

module canonical_huffman_code_builder_top #(
	parameter int MAX_LENGTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [chcb_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [chcb_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [chcb_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	// Channels
	chcb_in_if.sink                                table_in,
	chcb_out_if.source                             code_out
);
	import chcb_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN_L  = LEN_W'(MAX_LENGTH);
	localparam logic [LEN_W-1:0] NUM_CNT_L  = LEN_W'(NUM_COUNTS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_ADV,
		S_LOAD
	} state_t;

	state_t                 state_q;
	logic [LEN_W-1:0]       max_len_q;
	logic [LEN_W-1:0]       byte_pos_q;
	logic [LEN_W-1:0]       cur_len_q;
	logic [BYTE_W-1:0]      codes_left_q;
	logic [NCODE_W-1:0]     next_code_q;
	logic                   failed_q;
	logic [SYMS_W-1:0]      symbols_left_q;
	logic [SYMS_W-1:0]      sum_q;
	logic [LEN_W-1:0]       k_q;
	logic [LEN_W-1:0]       eff_max_q;
	logic                   rd_v_q;
	logic                   rd_first_q;
	logic [BYTE_W-1:0]      sym_q;
	logic [BYTE_W-1:0]      rd_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_symbol_q;
	logic [CODE_W-1:0]      out_code_q;
	logic [LEN_W-1:0]       out_len_q;
	logic                   out_status_q;
	logic                   out_last_q;

	logic [BYTE_W-1:0]      counts_mem [NUM_COUNTS];

	logic                   in_fire;
	logic                   cfg_write;
	logic                   count_phase;
	logic                   cnt_we;
	logic [CNT_IDX_W-1:0]   cnt_waddr;
	logic [CNT_IDX_W-1:0]   rd_addr;
	logic [LEN_W-1:0]       eff_max;
	logic [SYMS_W-1:0]      sum_next;
	logic                   adv_need;
	logic [NCODE_W-1:0]     slot_limit;
	logic                   fail_now;
	logic                   out_free;
	logic                   out_load;

	// Configuration register access.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready
		& (paddr[2] == REG_MAX_CODE_LENGTH);
	assign prdata    = (paddr[2] == REG_MAX_CODE_LENGTH) ?
		APB_DATA_W'(max_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_CODE_LENGTH_RESET;
		end else if (cfg_write) begin
			max_len_q <= pwdata[LEN_W-1:0];
		end
	end

	// Clamp the configured maximum into 1 .. MAX_LENGTH.
	always_comb begin
		eff_max = max_len_q;
		if (eff_max == '0) begin
			eff_max = LEN_W'(1);
		end
		if (eff_max > MAX_LEN_L) begin
			eff_max = MAX_LEN_L;
		end
	end

	// Input handshake and count byte write decode.
	assign table_in.ready = (state_q == S_IDLE);
	assign in_fire        = table_in.valid & table_in.ready;
	assign count_phase    = table_in.table_start | (byte_pos_q < NUM_CNT_L);
	assign cnt_we         = in_fire & count_phase;
	assign cnt_waddr      = table_in.table_start ? '0 : byte_pos_q[CNT_IDX_W-1:0];

	// The single read port serves the sum pass and the length advance.
	assign rd_addr  = (state_q == S_SUM) ? k_q[CNT_IDX_W-1:0] : cur_len_q[CNT_IDX_W-1:0];
	assign sum_next = sum_q + SYMS_W'(rd_v_q ? rd_q : '0);

	// Shared step: free slot check at the current length.
	assign adv_need   = (codes_left_q == '0) && (cur_len_q < NUM_CNT_L);
	assign slot_limit = NCODE_W'(1) << cur_len_q;
	assign fail_now   = failed_q | (next_code_q >= slot_limit);
	assign out_free   = ~out_valid_q | code_out.ready;
	assign out_load   = (state_q == S_ADV) && !adv_need && (codes_left_q != '0) && out_free;

	// Count memory: written by count bytes, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			counts_mem[cnt_waddr] <= table_in.table_byte;
		end
		rd_q <= counts_mem[rd_addr];
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			byte_pos_q     <= '0;
			cur_len_q      <= LEN_W'(1);
			codes_left_q   <= '0;
			next_code_q    <= '0;
			failed_q       <= 1'b0;
			symbols_left_q <= '0;
			sum_q          <= '0;
			k_q            <= '0;
			eff_max_q      <= '0;
			rd_v_q         <= 1'b0;
			rd_first_q     <= 1'b0;
			sym_q          <= '0;
			out_valid_q    <= 1'b0;
			out_symbol_q   <= '0;
			out_code_q     <= '0;
			out_len_q      <= '0;
			out_status_q   <= 1'b0;
			out_last_q     <= 1'b0;
		end else begin
			// A transfer on the output frees the register unless a new result takes it.
			if (out_valid_q && code_out.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (table_in.table_start) begin
							failed_q       <= 1'b0;
							symbols_left_q <= '0;
							byte_pos_q     <= LEN_W'(1);
						end else if (count_phase) begin
							byte_pos_q <= byte_pos_q + LEN_W'(1);
							// Last count byte: sample the maximum and sum the counts.
							if (byte_pos_q == NUM_CNT_L - LEN_W'(1)) begin
								eff_max_q   <= eff_max;
								k_q         <= '0;
								sum_q       <= '0;
								rd_v_q      <= 1'b0;
								rd_first_q  <= 1'b0;
								cur_len_q   <= LEN_W'(1);
								next_code_q <= '0;
								state_q     <= S_SUM;
							end
						end else if (symbols_left_q != '0) begin
							sym_q   <= table_in.table_byte;
							state_q <= S_ADV;
						end
					end
				end

				S_SUM: begin
					sum_q <= sum_next;
					if (rd_first_q) begin
						codes_left_q <= rd_q;
					end
					rd_v_q     <= (k_q < eff_max_q) && (k_q < NUM_CNT_L);
					rd_first_q <= (k_q == '0);
					if (k_q == NUM_CNT_L) begin
						symbols_left_q <= sum_next;
						state_q        <= S_IDLE;
					end else begin
						k_q <= k_q + LEN_W'(1);
					end
				end

				S_ADV: begin
					if (adv_need) begin
						// Move one length deeper; the count arrives next cycle.
						if (!failed_q) begin
							next_code_q <= {next_code_q[NCODE_W-2:0], 1'b0};
						end
						cur_len_q <= cur_len_q + LEN_W'(1);
						state_q   <= S_LOAD;
					end else if (codes_left_q == '0) begin
						symbols_left_q <= '0;
						state_q        <= S_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_symbol_q <= sym_q;
						out_code_q   <= fail_now ? '0 : next_code_q[CODE_W-1:0];
						out_len_q    <= cur_len_q;
						out_status_q <= fail_now;
						out_last_q   <= (symbols_left_q == SYMS_W'(1));
						failed_q     <= fail_now;
						if (!fail_now) begin
							next_code_q <= next_code_q + NCODE_W'(1);
						end
						codes_left_q   <= codes_left_q - BYTE_W'(1);
						symbols_left_q <= symbols_left_q - SYMS_W'(1);
						state_q        <= S_IDLE;
					end
				end

				S_LOAD: begin
					codes_left_q <= rd_q;
					state_q      <= S_ADV;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output channel.
	assign code_out.valid        = out_valid_q;
	assign code_out.symbol       = out_symbol_q;
	assign code_out.code_word    = out_code_q;
	assign code_out.code_length  = out_len_q;
	assign code_out.build_status = out_status_q;
	assign code_out.last_symbol  = out_last_q;

endmodule : canonical_huffman_code_builder_top

`default_nettype wire

[hdl/chcb_checker.sv]
// ============================================================================
// Code builder port checker
// Watches the output channel of the code builder over time.
// ============================================================================
`default_nettype none

module chcb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [chcb_pkg::BYTE_W-1:0]   symbol,
	input wire logic [chcb_pkg::CODE_W-1:0]   code_word,
	input wire logic [chcb_pkg::LEN_W-1:0]    code_length,
	input wire logic                          build_status,
	input wire logic                          last_symbol
);
	import chcb_pkg::*;

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable({symbol, code_word, code_length, build_status, last_symbol}))
		else $error("result payload changed while stalled");

	// Every code has a length of 1 to 16 bits.
	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (code_length != '0) && (code_length <= LEN_W'(NUM_COUNTS)))
		else $error("code length out of range");

	// A rejected table gives all-zero codes.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && build_status |-> (code_word == '0))
		else $error("nonzero code on a rejected table");

	// A good code fits within its length.
	a_code_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !build_status |->
			(({1'b0, code_word} >> code_length) == '0))
		else $error("code wider than its length");

endmodule : chcb_checker

bind canonical_huffman_code_builder_top chcb_checker u_chcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (code_out.valid),
	.out_ready    (code_out.ready),
	.symbol       (code_out.symbol),
	.code_word    (code_out.code_word),
	.code_length  (code_out.code_length),
	.build_status (code_out.build_status),
	.last_symbol  (code_out.last_symbol)
);

`default_nettype wire
